@@ src/msdsc_pkg.sv @@
// shared constants for the mips subset delay slot core
package msdsc_pkg;

  localparam int unsigned MEM_WORDS_DEFAULT = 4096;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ADDR_W  = 12;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START = 2'd2;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd3;

  // run status codes
  localparam logic [STAT_W-1:0] STAT_RUN     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SYSCALL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNIMPL  = 2'd2;

  // opcodes and function codes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADDU    = 6'h21;

  // register words with a fixed role
  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [DATA_W-1:0] SP_INIT    = 32'h0000_0800;
  localparam logic [DATA_W-1:0] EXIT_CODE  = 32'd10;
  localparam logic [ADDR_W-1:0] START_WORD_RESET = 12'd64;

endpackage

@@ src/mips_subset_delay_slot_core.sv @@
// top level: mips32 subset interpreter over one shared word memory
//
// Usage: a transaction is taken at a rising edge with start high and busy low;
// req_type selects write word, read word, start or step one instruction.
// Every transaction gives exactly one result, shown for one cycle with done
// high: read_data (the word for a read, else zero), fetch_word and run_status.
// Write, start and a step while halted raise done in the cycle after the
// accepting edge; a read goes through ST_RD first; a step goes through
// fetch, read rs, read rt, execute and write back, all bound by the single
// port of the word memory. Busy is high while a read or step is in flight;
// a new transaction may be taken in the cycle that done is high.
// start_word is written through cfg_wr_en/cfg_wr_data by the user only while
// idle; the block does not enforce it. Reset clears the pointers, the run status
// and start_word (to 64); the word memory is not cleared and holds whatever it
// held until written. MEM_WORDS is a power of two; all word addresses wrap at
// that depth. The receiver cannot stall: each result is taken in its done cycle.
module mips_subset_delay_slot_core #(
  parameter int unsigned MEM_WORDS = msdsc_pkg::MEM_WORDS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [msdsc_pkg::REQ_W-1:0]     req_type,
  input  logic [msdsc_pkg::ADDR_W-1:0]    word_addr,
  input  logic [msdsc_pkg::DATA_W-1:0]    write_data,
  input  logic                            cfg_wr_en,
  input  logic [msdsc_pkg::ADDR_W-1:0]    cfg_wr_data,
  output logic                            done,
  output logic [msdsc_pkg::DATA_W-1:0]    read_data,
  output logic [msdsc_pkg::ADDR_W-1:0]    fetch_word,
  output logic [msdsc_pkg::STAT_W-1:0]    run_status
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_A    = 3'd3;
  localparam logic [2:0] ST_B    = 3'd4;

  logic [2:0]                         state;
  logic [2:0]                         state_next;
  logic [AW-1:0]                      fetch_pointer;
  logic [AW-1:0]                      next_pointer;
  logic [msdsc_pkg::STAT_W-1:0]       halt_status;
  logic [msdsc_pkg::ADDR_W-1:0]       start_word;
  logic [msdsc_pkg::DATA_W-1:0]       ins;
  logic [msdsc_pkg::DATA_W-1:0]       opa;

  logic                               mem_we;
  logic [AW-1:0]                      mem_addr;
  logic [msdsc_pkg::DATA_W-1:0]       mem_wdata;
  logic [msdsc_pkg::DATA_W-1:0]       mem_rdata;

  logic                               accept;
  logic [AW-1:0]                      req_addr;
  logic [AW-1:0]                      start_ptr;

  // decode of the latched instruction
  logic [5:0]                         op;
  logic [5:0]                         fn;
  logic [msdsc_pkg::DATA_W-1:0]       simm;
  logic [msdsc_pkg::DATA_W-1:0]       sum;
  logic [AW-1:0]                      inc_ptr;
  logic                               raw_is_syscall;

  logic                               exec_we;
  logic [AW-1:0]                      exec_addr;
  logic [msdsc_pkg::DATA_W-1:0]       exec_data;
  logic [AW-1:0]                      exec_next;
  logic [msdsc_pkg::STAT_W-1:0]       exec_status;

  msdsc_ram #(
    .WIDTH(msdsc_pkg::DATA_W),
    .DEPTH(MEM_WORDS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign req_addr   = AW'(word_addr);
  assign start_ptr  = AW'(start_word);
  assign fetch_word = msdsc_pkg::ADDR_W'(fetch_pointer);
  assign run_status = halt_status;

  assign op      = ins[31:26];
  assign fn      = ins[5:0];
  assign simm    = {{16{ins[15]}}, ins[15:0]};
  assign inc_ptr = next_pointer + AW'(1);
  // addu adds the rt word, everything else that adds uses the immediate
  assign sum     = opa + ((op == msdsc_pkg::OP_SPECIAL) ? mem_rdata : simm);
  assign raw_is_syscall = (mem_rdata[31:26] == msdsc_pkg::OP_SPECIAL) &&
                          (mem_rdata[5:0] == msdsc_pkg::FN_SYSCALL);

  // execute stage, rt word arrives on mem_rdata
  always_comb begin
    exec_we     = 1'b0;
    exec_addr   = AW'(ins[20:16]);
    exec_data   = sum;
    exec_next   = inc_ptr;
    exec_status = halt_status;
    if (ins != '0) begin
      case (op)
        msdsc_pkg::OP_SPECIAL: begin
          case (fn)
            msdsc_pkg::FN_JR: exec_next = AW'(opa);
            msdsc_pkg::FN_SYSCALL: begin
              if (opa == msdsc_pkg::EXIT_CODE) begin
                exec_status = msdsc_pkg::STAT_SYSCALL;
              end
            end
            msdsc_pkg::FN_ADDU: begin
              exec_we   = 1'b1;
              exec_addr = AW'(ins[15:11]);
            end
            default: exec_status = msdsc_pkg::STAT_UNIMPL;
          endcase
        end
        msdsc_pkg::OP_ADDIU: exec_we = 1'b1;
        msdsc_pkg::OP_SW: begin
          exec_we   = 1'b1;
          exec_addr = sum[AW+1:2];
          exec_data = mem_rdata;
        end
        msdsc_pkg::OP_JAL: begin
          exec_we   = 1'b1;
          exec_addr = AW'(msdsc_pkg::REG_RA);
          exec_data = msdsc_pkg::DATA_W'(inc_ptr);
          exec_next = ins[AW-1:0];
        end
        msdsc_pkg::OP_BNE: begin
          if (opa != mem_rdata) begin
            exec_next = next_pointer + AW'(simm);
          end
        end
        msdsc_pkg::OP_LUI: begin
          exec_we   = 1'b1;
          exec_data = {ins[15:0], 16'h0000};
        end
        default: exec_status = msdsc_pkg::STAT_UNIMPL;
      endcase
    end
  end

  // memory port and next state
  always_comb begin
    mem_we     = 1'b0;
    mem_addr   = fetch_pointer;
    mem_wdata  = write_data;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            msdsc_pkg::REQ_WRITE: begin
              mem_we   = 1'b1;
              mem_addr = req_addr;
            end
            msdsc_pkg::REQ_READ: begin
              mem_addr   = req_addr;
              state_next = ST_RD;
            end
            msdsc_pkg::REQ_START: begin
              mem_we    = 1'b1;
              mem_addr  = AW'(msdsc_pkg::REG_SP);
              mem_wdata = msdsc_pkg::SP_INIT;
            end
            default: begin
              if (halt_status == msdsc_pkg::STAT_RUN) begin
                state_next = ST_INS;
              end
            end
          endcase
        end
      end
      ST_RD: state_next = ST_IDLE;
      ST_INS: begin
        mem_addr   = raw_is_syscall ? AW'(msdsc_pkg::REG_V0) : AW'(mem_rdata[25:21]);
        state_next = ST_A;
      end
      ST_A: begin
        mem_addr   = AW'(ins[20:16]);
        state_next = ST_B;
      end
      ST_B: begin
        mem_we     = exec_we;
        mem_addr   = exec_addr;
        mem_wdata  = exec_data;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fetch_pointer <= '0;
      next_pointer  <= '0;
      halt_status   <= msdsc_pkg::STAT_RUN;
      start_word    <= msdsc_pkg::START_WORD_RESET;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_wr_en) begin
        start_word <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type == msdsc_pkg::REQ_START) begin
              fetch_pointer <= start_ptr;
              next_pointer  <= start_ptr + AW'(1);
              halt_status   <= msdsc_pkg::STAT_RUN;
            end
            // a step while halted completes at once
            if (req_type != msdsc_pkg::REQ_READ &&
                !(req_type == msdsc_pkg::REQ_STEP && halt_status == msdsc_pkg::STAT_RUN)) begin
              done <= 1'b1;
            end
          end
        end
        ST_RD: done <= 1'b1;
        ST_B: begin
          fetch_pointer <= next_pointer;
          next_pointer  <= exec_next;
          halt_status   <= exec_status;
          done          <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result word and operand latches
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      read_data <= mem_rdata;
    end else begin
      read_data <= '0;
    end
    if (state == ST_INS) begin
      ins <= mem_rdata;
    end
    if (state == ST_A) begin
      opa <= mem_rdata;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done strobe while busy");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == msdsc_pkg::REQ_WRITE) |=> done)
    else $error("write transaction did not complete in one cycle");

  a_halted_step: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == msdsc_pkg::REQ_STEP && halt_status != msdsc_pkg::STAT_RUN)
    |=> (done && $stable(fetch_word) && $stable(run_status)))
    else $error("step while halted changed state");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (halt_status != msdsc_pkg::STAT_RUN && !(accept && req_type == msdsc_pkg::REQ_START))
    |=> $stable(halt_status))
    else $error("halt status left without a start");

endmodule

@@ src/msdsc_ram.sv @@
// generic single-port synchronous ram with registered read
module msdsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sim/mips_subset_delay_slot_core_checker.sv @@
`timescale 1ns / 1ps
// checker for the mips subset core: predicts each transaction's result and compares
module mips_subset_delay_slot_core_checker
  import msdsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ADDR_W-1:0] word_addr,
  input  logic [DATA_W-1:0] write_data,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  input  logic              done,
  input  logic [DATA_W-1:0] read_data,
  input  logic [ADDR_W-1:0] fetch_word,
  input  logic [STAT_W-1:0] run_status,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [ADDR_W-1:0] fetch;
    logic [STAT_W-1:0] status;
  } outcome_t;

  logic [DATA_W-1:0] words [0:MEM_WORDS_DEFAULT-1];
  logic [ADDR_W-1:0] pc_q;
  logic [ADDR_W-1:0] npc_q;
  logic [ADDR_W-1:0] entry_word;
  logic [STAT_W-1:0] stat_q;
  outcome_t          expected_outcomes[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("mismatch at %0t ns: %s is %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void execute_instruction();
    logic [DATA_W-1:0] ins;
    logic [DATA_W-1:0] simm;
    logic [DATA_W-1:0] byte_addr;
    logic [5:0]        op;
    logic [5:0]        fn;
    logic [4:0]        rs;
    logic [4:0]        rt;
    logic [4:0]        rd;
    logic [ADDR_W-1:0] old_next;
    logic [ADDR_W-1:0] new_next;
    ins      = words[pc_q];
    op       = ins[31:26];
    fn       = ins[5:0];
    rs       = ins[25:21];
    rt       = ins[20:16];
    rd       = ins[15:11];
    simm     = {{16{ins[15]}}, ins[15:0]};
    old_next = npc_q;
    new_next = npc_q + 1'b1;
    pc_q     = old_next;
    if (ins != '0) begin
      case (op)
        OP_SPECIAL: begin
          if (fn == FN_JR)
            new_next = words[rs][ADDR_W-1:0];
          else if (fn == FN_SYSCALL) begin
            if (words[REG_V0] == EXIT_CODE) stat_q = STAT_SYSCALL;
          end else if (fn == FN_ADDU)
            words[rd] = words[rs] + words[rt];
          else
            stat_q = STAT_UNIMPL;
        end
        OP_ADDIU: words[rt] = words[rs] + simm;
        OP_SW: begin
          byte_addr = words[rs] + simm;
          words[byte_addr[ADDR_W+1:2]] = words[rt];
        end
        OP_JAL: begin
          words[REG_RA] = {{(DATA_W-ADDR_W){1'b0}}, old_next + 1'b1};
          new_next      = ins[ADDR_W-1:0];
        end
        OP_BNE: if (words[rs] != words[rt]) new_next = old_next + simm[ADDR_W-1:0];
        OP_LUI: words[rt] = {ins[15:0], 16'h0000};
        default: stat_q = STAT_UNIMPL;
      endcase
    end
    npc_q = new_next;
  endfunction

  function automatic outcome_t apply_request(input logic [REQ_W-1:0] kind,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [DATA_W-1:0] data);
    outcome_t res;
    res.rdata = '0;
    case (kind)
      REQ_WRITE: words[addr] = data;
      REQ_READ:  res.rdata = words[addr];
      REQ_START: begin
        pc_q          = entry_word;
        npc_q         = entry_word + 1'b1;
        words[REG_SP] = SP_INIT;
        stat_q        = STAT_RUN;
      end
      default: if (stat_q == STAT_RUN) execute_instruction();
    endcase
    res.fetch  = pc_q;
    res.status = stat_q;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      pc_q       = '0;
      npc_q      = '0;
      stat_q     = STAT_RUN;
      entry_word = START_WORD_RESET;
      expected_outcomes.delete();
    end else begin
      // retire before taking a new transaction, both can share an edge
      if (done === 1'b1) begin
        if (expected_outcomes.size() == 0) begin
          report("result with no transaction pending, read_data", read_data, '0);
        end else begin
          want = expected_outcomes.pop_front();
          if (read_data !== want.rdata) report("read_data", read_data, want.rdata);
          if (fetch_word !== want.fetch)
            report("fetch_word", DATA_W'(fetch_word), DATA_W'(want.fetch));
          if (run_status !== want.status)
            report("run_status", DATA_W'(run_status), DATA_W'(want.status));
        end
      end
      if (cfg_wr_en === 1'b1) entry_word = cfg_wr_data;
      if (start === 1'b1 && busy === 1'b0)
        expected_outcomes.push_back(apply_request(req_type, word_addr, write_data));
    end
    pending_count = expected_outcomes.size();
  end

endmodule

@@ sim/mips_subset_delay_slot_core_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the mips subset core: stimulus, clock, reset and verdict
module mips_subset_delay_slot_core_tb;
  import msdsc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1650;

  // encodings the core does not implement
  localparam logic [5:0] OP_J   = 6'h02;
  localparam logic [5:0] FN_SLT = 6'h2A;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              start       = 1'b0;
  logic [REQ_W-1:0]  req_type    = REQ_WRITE;
  logic [ADDR_W-1:0] word_addr   = '0;
  logic [DATA_W-1:0] write_data  = '0;
  logic              cfg_wr_en   = 1'b0;
  logic [ADDR_W-1:0] cfg_wr_data = '0;
  logic              busy;
  logic              done;
  logic [DATA_W-1:0] read_data;
  logic [ADDR_W-1:0] fetch_word;
  logic [STAT_W-1:0] run_status;

  int                fail_count;
  int                pending_count;
  int                items       = 0;
  int                cycle_count = 0;
  int                idle_pct    = 0;
  int                phase       = 0;
  int                span;
  logic [ADDR_W-1:0] code_base   = START_WORD_RESET;

  mips_subset_delay_slot_core uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .word_addr   (word_addr),
    .write_data  (write_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .read_data   (read_data),
    .fetch_word  (fetch_word),
    .run_status  (run_status)
  );

  mips_subset_delay_slot_core_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .word_addr     (word_addr),
    .write_data    (write_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .read_data     (read_data),
    .fetch_word    (fetch_word),
    .run_status    (run_status),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] r_type(input logic [4:0] rs, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] random_instruction(input int len);
    int          pick;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    logic [31:0] ins;
    pick = $urandom_range(0, 99);
    rs   = 5'($urandom);
    rt   = 5'($urandom);
    rd   = 5'($urandom);
    imm  = 16'($urandom);
    if (pick < 14) begin
      ins = r_type(rs, rt, rd, FN_ADDU);
    end else if (pick < 32) begin
      ins = i_type(OP_ADDIU, rs, rt, imm);
    end else if (pick < 44) begin
      ins = i_type(OP_SW, rs, rt, imm);
    end else if (pick < 53) begin
      ins = i_type(OP_LUI, rs, rt, imm);
    end else if (pick < 65) begin
      if ($urandom_range(0, 3) == 0) rt = rs;
      // mostly short hops that stay inside the code
      if ($urandom_range(0, 4) != 0) imm = 16'($urandom_range(0, 16)) - 16'd8;
      ins = i_type(OP_BNE, rs, rt, imm);
    end else if (pick < 71) begin
      ins = {OP_JAL, 14'($urandom), code_base + 12'($urandom_range(0, len - 1))};
    end else if (pick < 76) begin
      ins = r_type(rs, rt, rd, FN_JR);
    end else if (pick < 83) begin
      ins = {OP_SPECIAL, 20'($urandom), FN_SYSCALL};
    end else if (pick < 96) begin
      ins = '0;
    end else if (pick < 98) begin
      op = 6'($urandom);
      while (op == OP_SPECIAL || op == OP_JAL || op == OP_BNE || op == OP_ADDIU ||
             op == OP_LUI || op == OP_SW)
        op = 6'($urandom);
      ins = {op, 26'($urandom)};
    end else begin
      fn = 6'($urandom);
      while (fn == FN_JR || fn == FN_SYSCALL || fn == FN_ADDU) fn = 6'($urandom);
      ins = {OP_SPECIAL, 20'($urandom), fn};
      if (ins == '0) ins[6] = 1'b1;
    end
    return ins;
  endfunction

  // one transaction; start stays high across back-to-back transactions
  task automatic transact(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= kind;
    word_addr  <= addr;
    write_data <= data;
    do @(posedge clk); while (busy !== 1'b0);
    items++;
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // a write or start may still be finishing inside the core
    repeat (6) @(posedge clk);
  endtask

  task automatic set_code_base(input logic [ADDR_W-1:0] value);
    quiesce();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    code_base = value;
  endtask

  task automatic load_code(input int len);
    int                pick;
    logic [DATA_W-1:0] value;
    for (int r = 0; r < 32; r++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        value = {20'd0, code_base + 12'($urandom_range(0, len - 1))};
      else if (pick < 7)
        value = $urandom_range(0, 16383);
      else if (pick == 7 && r == REG_V0)
        value = EXIT_CODE;
      else
        value = $urandom;
      if ($urandom_range(0, 1) == 0) transact(REQ_WRITE, ADDR_W'(r), value);
    end
    for (int i = 0; i < len; i++)
      transact(REQ_WRITE, code_base + ADDR_W'(i), random_instruction(len));
  endtask

  task automatic run_code(input int steps);
    int pick;
    transact(REQ_START, ADDR_W'($urandom), $urandom);
    for (int k = 0; k < steps; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        transact(REQ_STEP, ADDR_W'($urandom), $urandom);
      else if (pick < 87)
        transact(REQ_READ, ADDR_W'($urandom), $urandom);
      else if (pick < 91)
        transact(REQ_WRITE, ADDR_W'($urandom), $urandom);
      else if (pick < 94)
        transact(REQ_WRITE, ADDR_W'(REG_V0), EXIT_CODE);
      else if (pick < 97)
        transact(REQ_START, ADDR_W'($urandom), $urandom);
      else
        transact(REQ_WRITE, ADDR_W'($urandom_range(0, 31)), $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // memory powers up unknown: give every word a value before anything reads it
    for (int a = 0; a < MEM_WORDS_DEFAULT; a++) transact(REQ_WRITE, ADDR_W'(a), '0);

    // directed: runs from the reset start word
    transact(REQ_STEP, '0, '0);  // before any start, word 0 is a no-op
    transact(REQ_WRITE, 12'd4095, 32'hFFFF_FFFF);
    transact(REQ_READ, 12'd4095, '0);
    transact(REQ_WRITE, 12'd1, 32'hFFFF_FFFF);
    transact(REQ_WRITE, 12'd3, 32'd1);
    transact(REQ_WRITE, 12'd64, r_type(5'd1, 5'd3, 5'd4, FN_ADDU));
    transact(REQ_WRITE, 12'd65, i_type(OP_ADDIU, 5'd3, 5'd5, 16'hFFE1));
    transact(REQ_WRITE, 12'd66, i_type(OP_LUI, 5'd0, 5'd6, 16'h8000));
    transact(REQ_WRITE, 12'd67, i_type(OP_SW, REG_SP, 5'd1, 16'hFFFC));
    transact(REQ_WRITE, 12'd68, i_type(OP_BNE, 5'd1, 5'd3, 16'd3));
    transact(REQ_WRITE, 12'd72, {OP_JAL, 26'h3FF_F050});  // target wraps to word 80
    transact(REQ_WRITE, 12'd73, i_type(OP_BNE, 5'd3, 5'd3, 16'd5));
    transact(REQ_WRITE, 12'd80, r_type(REG_RA, 5'd0, 5'd0, FN_JR));
    transact(REQ_WRITE, 12'd81, r_type(5'd4, 5'd5, 5'd7, FN_ADDU));
    transact(REQ_WRITE, 12'd74, {OP_SPECIAL, 20'd0, FN_SYSCALL});
    transact(REQ_WRITE, 12'd75, i_type(OP_ADDIU, 5'd0, REG_V0, 16'd10));
    transact(REQ_WRITE, 12'd76, {OP_SPECIAL, 20'd0, FN_SYSCALL});
    transact(REQ_START, '0, '0);
    repeat (14) transact(REQ_STEP, '0, '0);  // last one lands while halted
    transact(REQ_READ, 12'd511, '0);
    transact(REQ_READ, ADDR_W'(REG_RA), '0);
    transact(REQ_WRITE, 12'd64, {OP_J, 26'd100});
    transact(REQ_START, '0, '0);
    repeat (2) transact(REQ_STEP, '0, '0);
    transact(REQ_WRITE, 12'd64, r_type(5'd1, 5'd3, 5'd4, FN_SLT));
    transact(REQ_START, '0, '0);
    transact(REQ_STEP, '0, '0);

    // random phases, each with its own start word
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (items > RANDOM_ITEMS - 250)
        idle_pct = 0;
      else
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      if (phase == 0)
        set_code_base(12'd0);
      else if (phase == 1)
        set_code_base(12'd4095);
      else if (phase == 2)
        set_code_base(12'd4090);
      else
        set_code_base(ADDR_W'($urandom));
      if (phase % 6 == 5) begin
        // unstructured traffic
        repeat (40) transact(REQ_W'($urandom), ADDR_W'($urandom), $urandom);
      end else begin
        span = $urandom_range(8, 24);
        load_code(span);
        run_code($urandom_range(30, 80));
      end
      phase++;
    end

    quiesce();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ mips_subset_delay_slot_core.f @@
src/msdsc_pkg.sv
src/msdsc_ram.sv
src/mips_subset_delay_slot_core.sv
sim/mips_subset_delay_slot_core_checker.sv
sim/mips_subset_delay_slot_core_tb.sv
